// ===== rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the quintic trajectory evaluator.
// No dependencies; every other file of the block but qte_queue imports this package.
package qte_pkg;

  // Field widths
  localparam int DATA_W    = 32;               // Q16.16 registers and results
  localparam int TIME_W    = 17;               // Q1.16 time, one integer bit for 1.0
  localparam int TIME_FRAC = 16;
  localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC;
  localparam int TIME_HALF = 1 << (TIME_FRAC - 1);

  // Doubled coefficients and Horner accumulators stay below 2^45 in magnitude
  localparam int ACC_W  = 48;
  localparam int PROD_W = ACC_W + TIME_W + 1;

  // Configuration register map
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_ACC = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_END_POS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_END_ACC   = CFG_IDX_W'(5);

  // Polynomial term counts: position, first and second derivative
  localparam int POS_TERMS = 6;
  localparam int VEL_TERMS = 5;
  localparam int ACC_TERMS = 4;

  // Cycles the input is held off after a register write while coefficients settle
  localparam int SETTLE_CYCLES = 6;
  localparam int SETTLE_W      = 3;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Doubled coefficients, highest power first
  typedef struct packed {
    logic [POS_TERMS-1:0][ACC_W-1:0] pc;
    logic [VEL_TERMS-1:0][ACC_W-1:0] vc;
    logic [ACC_TERMS-1:0][ACC_W-1:0] ac;
  } coef_t;

  // One Horner step: floor((acc*t + half) / 2^16) + c
  function automatic logic signed [ACC_W-1:0] horner_step(
      input logic signed [ACC_W-1:0] acc,
      input logic [TIME_W-1:0]       t,
      input logic signed [ACC_W-1:0] c);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    prod    = acc * $signed({1'b0, t});
    prod    = prod + PROD_W'(TIME_HALF);
    shifted = prod >>> TIME_FRAC;
    return $signed(shifted[ACC_W-1:0]) + c;
  endfunction

  // Undo the doubling with round half up, then clamp to the result range
  function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] d);
    logic signed [ACC_W:0] dx;
    logic signed [ACC_W:0] r;
    logic                  fits;
    dx   = {d[ACC_W-1], d};
    dx   = dx + (ACC_W+1)'(1);
    r    = dx >>> 1;
    fits = (r[ACC_W:DATA_W-1] == '0) || (r[ACC_W:DATA_W-1] == '1);
    if (fits) begin
      return r[DATA_W-1:0];
    end else if (r[ACC_W]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/qte_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for time samples in and trajectory results out.
// Depends on qte_pkg for field widths.
interface qte_in_if;
  import qte_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_point;

  modport source (output valid, output time_point, input ready);
  modport sink   (input valid, input time_point, output ready);
endinterface

interface qte_out_if;
  import qte_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] velocity;
  logic signed [DATA_W-1:0] acceleration;

  modport source (output valid, output position, output velocity, output acceleration,
                  input ready);
  modport sink   (input valid, input position, input velocity, input acceleration,
                  output ready);
endinterface

// ===== rtl/quintic_trajectory_evaluator.sv =====
`timescale 1ns / 1ps
// Quintic trajectory evaluator: one time beat in, one position/velocity/acceleration out.
// Throughput: one beat per cycle through the six-stage Horner pipeline while the output
// is not stalled. After reset and after each register write the input is held off while
// the coefficient pipeline settles. Reset (rst_n, synchronous, active low) zeroes all six
// registers and empties the queue and pipeline.
module quintic_trajectory_evaluator #(
  parameter int QUEUE_DEPTH = qte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qte_pkg::DATA_W-1:0]     cfg_data,
  qte_in_if.sink                         in_chan,
  qte_out_if.source                      out_chan
);
  import qte_pkg::*;

  coef_t             coef;
  logic              push, pop, q_full, q_empty;
  logic [TIME_W-1:0] push_data, pop_data;

  qte_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  qte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .in_chan    (in_chan),
    .queue_full (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  qte_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (TIME_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  qte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef        (coef),
    .queue_empty (q_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule

// ===== rtl/qte_coef.sv =====
`timescale 1ns / 1ps
// Boundary-condition registers and the five-stage pipeline that forms the doubled
// position, velocity and acceleration coefficients. Depends on qte_pkg.
module qte_coef (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qte_pkg::DATA_W-1:0]     cfg_data,
  output qte_pkg::coef_t                 coef
);
  import qte_pkg::*;

  logic signed [DATA_W-1:0] p0_r, v0_r, c0_r, p1_r, v1_r, c1_r;

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= '0;
      v0_r <= '0;
      c0_r <= '0;
      p1_r <= '0;
      v1_r <= '0;
      c1_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_POS: p0_r <= cfg_data;
        REG_START_VEL: v0_r <= cfg_data;
        REG_START_ACC: c0_r <= cfg_data;
        REG_END_POS:   p1_r <= cfg_data;
        REG_END_VEL:   v1_r <= cfg_data;
        REG_END_ACC:   c1_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [ACC_W-1:0] p0x, v0x, c0x, p1x, v1x, c1x;
  assign p0x = ACC_W'(p0_r);
  assign v0x = ACC_W'(v0_r);
  assign c0x = ACC_W'(c0_r);
  assign p1x = ACC_W'(p1_r);
  assign v1x = ACC_W'(v1_r);
  assign c1x = ACC_W'(c1_r);

  logic signed [ACC_W-1:0] b0_1_r, b1_1_r, b2_1_r, y1_1_r, y2_1_r, y3_1_r;
  logic signed [ACC_W-1:0] b0_2_r, b1_2_r, b2_2_r, y1_2_r, y2_2_r, b3_2_r;
  logic signed [ACC_W-1:0] b0_3_r, b1_3_r, b2_3_r, y1_3_r, b3_3_r, b4_3_r;
  logic signed [ACC_W-1:0] b0_4_r, b1_4_r, b2_4_r, b3_4_r, b4_4_r, b5_4_r;
  coef_t                   coef_r;

  always_ff @(posedge clk) begin
    // stage 1: low coefficients and boundary residuals
    b0_1_r <= p0x <<< 1;
    b1_1_r <= v0x <<< 1;
    b2_1_r <= c0x;
    y1_1_r <= (p1x <<< 1) - (p0x <<< 1) - (v0x <<< 1) - c0x;
    y2_1_r <= (v1x <<< 1) - (v0x <<< 1) - (c0x <<< 1);
    y3_1_r <= c1x - c0x;

    // stage 2: b3 = 10 y1 - 4 y2 + y3
    b0_2_r <= b0_1_r;
    b1_2_r <= b1_1_r;
    b2_2_r <= b2_1_r;
    y1_2_r <= y1_1_r;
    y2_2_r <= y2_1_r;
    b3_2_r <= (y1_1_r <<< 3) + (y1_1_r <<< 1) - (y2_1_r <<< 2) + y3_1_r;

    // stage 3: b4 = 5 y1 - y2 - 2 b3
    b0_3_r <= b0_2_r;
    b1_3_r <= b1_2_r;
    b2_3_r <= b2_2_r;
    y1_3_r <= y1_2_r;
    b3_3_r <= b3_2_r;
    b4_3_r <= (y1_2_r <<< 2) + y1_2_r - y2_2_r - (b3_2_r <<< 1);

    // stage 4: b5 = y1 - b4 - b3
    b0_4_r <= b0_3_r;
    b1_4_r <= b1_3_r;
    b2_4_r <= b2_3_r;
    b3_4_r <= b3_3_r;
    b4_4_r <= b4_3_r;
    b5_4_r <= y1_3_r - b4_3_r - b3_3_r;

    // stage 5: derivative coefficient scaling
    coef_r.pc[0] <= b5_4_r;
    coef_r.pc[1] <= b4_4_r;
    coef_r.pc[2] <= b3_4_r;
    coef_r.pc[3] <= b2_4_r;
    coef_r.pc[4] <= b1_4_r;
    coef_r.pc[5] <= b0_4_r;
    coef_r.vc[0] <= (b5_4_r <<< 2) + b5_4_r;
    coef_r.vc[1] <= b4_4_r <<< 2;
    coef_r.vc[2] <= (b3_4_r <<< 1) + b3_4_r;
    coef_r.vc[3] <= b2_4_r <<< 1;
    coef_r.vc[4] <= b1_4_r;
    coef_r.ac[0] <= (b5_4_r <<< 4) + (b5_4_r <<< 2);
    coef_r.ac[1] <= (b4_4_r <<< 3) + (b4_4_r <<< 2);
    coef_r.ac[2] <= (b3_4_r <<< 2) + (b3_4_r <<< 1);
    coef_r.ac[3] <= b2_4_r <<< 1;
  end

  assign coef = coef_r;

endmodule

// ===== rtl/qte_queue.sv =====
`timescale 1ns / 1ps
// Small register FIFO between the accepting front and the evaluation back end.
// Standalone; no package dependency.
module qte_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== rtl/qte_front.sv =====
`timescale 1ns / 1ps
// Input side: accepts time beats, clamps them to 1.0 and pushes them into the queue;
// holds the input off while coefficients settle after a register write. Uses qte_pkg.
module qte_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  qte_in_if.sink                      in_chan,
  input  logic                        queue_full,
  output logic                        push,
  output logic [qte_pkg::TIME_W-1:0]  push_data
);
  import qte_pkg::*;

  logic [SETTLE_W-1:0] settle_r;

  // settle countdown, restarted by every register write and by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (cfg_we) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign in_chan.ready = !queue_full && (settle_r == '0);
  assign push          = in_chan.valid && in_chan.ready;

  // times past 1.0 evaluate at 1.0
  assign push_data = (in_chan.time_point > TIME_ONE) ? TIME_ONE : in_chan.time_point;

  a_hold_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_chan.ready)
    else $error("input taken while coefficients settle");

  a_time_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_data <= TIME_ONE)
    else $error("queued time beyond 1.0");

endmodule

// ===== rtl/qte_back.sv =====
`timescale 1ns / 1ps
// Evaluation back end: three Horner lanes in a lockstep six-stage pipeline,
// then rounding, saturation and the output register. Uses qte_pkg and qte_out_if.
module qte_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qte_pkg::coef_t              coef,
  input  logic                        queue_empty,
  input  logic [qte_pkg::TIME_W-1:0]  queue_data,
  output logic                        pop,
  qte_out_if.source                   out_chan
);
  import qte_pkg::*;

  localparam int NSTG      = POS_TERMS;
  localparam int VEL_START = POS_TERMS - VEL_TERMS + 1;
  localparam int ACC_START = POS_TERMS - ACC_TERMS + 1;

  logic                    adv;
  logic [NSTG-1:0]         vld_r;
  logic [TIME_W-1:0]       t_r [NSTG-1];
  logic signed [ACC_W-1:0] p_r [NSTG];
  logic signed [ACC_W-1:0] v_r [NSTG];
  logic signed [ACC_W-1:0] a_r [NSTG];
  logic                    out_valid_r;
  logic [DATA_W-1:0]       pos_r, vel_r, acc_r;

  // whole pipeline moves unless a finished result is stuck at the output
  assign adv = !out_valid_r || out_chan.ready;
  assign pop = adv && !queue_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], pop};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // stage 0: time enters with the leading coefficient of each lane
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0] <= queue_data;
      p_r[0] <= $signed(coef.pc[0]);
      v_r[0] <= $signed(coef.vc[0]);
      a_r[0] <= $signed(coef.ac[0]);
    end
  end

  // stages 1..5: one Horner step per lane; shorter lanes join later
  for (genvar s = 1; s < NSTG; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        p_r[s] <= horner_step(p_r[s-1], t_r[s-1], $signed(coef.pc[s]));
      end
    end

    // time rides along only as far as the last step needs it
    if (s < NSTG - 1) begin : g_time
      always_ff @(posedge clk) begin
        if (adv) begin
          t_r[s] <= t_r[s-1];
        end
      end
    end

    if (s >= VEL_START) begin : g_vel
      always_ff @(posedge clk) begin
        if (adv) begin
          v_r[s] <= horner_step(v_r[s-1], t_r[s-1], $signed(coef.vc[s-VEL_START+1]));
        end
      end
    end else begin : g_vel_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end

    if (s >= ACC_START) begin : g_acc
      always_ff @(posedge clk) begin
        if (adv) begin
          a_r[s] <= horner_step(a_r[s-1], t_r[s-1], $signed(coef.ac[s-ACC_START+1]));
        end
      end
    end else begin : g_acc_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          a_r[s] <= a_r[s-1];
        end
      end
    end
  end

  // output register: halve, round, saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= round_sat(p_r[NSTG-1]);
      vel_r <= round_sat(v_r[NSTG-1]);
      acc_r <= round_sat(a_r[NSTG-1]);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.position     = pos_r;
  assign out_chan.velocity     = vel_r;
  assign out_chan.acceleration = acc_r;

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !pop)
    else $error("queue popped while output stalled");

endmodule
